/* rtl/mutb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank package
// Shared widths, command codes and state encoding for the timer bank.
// ----------------------------------------------------------------------------
package mutb_pkg;

  localparam int MaxUsers     = 16;
  localparam int SlotsPerUser = 8;
  localparam int UserW        = 4;
  localparam int SlotW        = 3;
  localparam int AddrW        = UserW + SlotW;
  localparam int Depth        = MaxUsers * SlotsPerUser;
  localparam int SlotDataW    = 32;

  localparam logic [31:0] SlotMax  = 32'h7fff_ffff;
  localparam logic [31:0] SlotIdle = 32'hffff_ffff;

  typedef enum logic [2:0] {
    KIND_SET    = 3'd0,
    KIND_CANCEL = 3'd1,
    KIND_READ   = 3'd2,
    KIND_CANALL = 3'd3,
    KIND_POLL   = 3'd4
  } kind_t;

  typedef enum logic [0:0] {
    CFG_USER_COUNT  = 1'd0,
    CFG_FIRST_EVENT = 1'd1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RD,
    ST_RMW,
    ST_CANALL,
    ST_SCAN,
    ST_TAKE,
    ST_TAKE_WB,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  user_index;
    logic [7:0]  timer_event;
    logic [31:0] period;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic        event_valid;
    logic [3:0]  event_user;
    logic [7:0]  event_timer;
    logic [30:0] remaining;
    logic        bad_timer;
  } out_item_t;

  typedef struct packed {
    logic [0:0]  index;
    logic [31:0] data;
  } cfg_item_t;

endpackage

/* rtl/mutb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank channels
// Valid/ready interfaces for command, result and configuration items.
// ----------------------------------------------------------------------------
interface mutb_in_if;
  logic               valid;
  logic               ready;
  mutb_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mutb_out_if;
  logic                valid;
  logic                ready;
  mutb_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mutb_cfg_if;
  logic                valid;
  logic                ready;
  mutb_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/mutb_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module mutb_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* rtl/multi_user_timer_bank_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-user timer bank
// Lazy second-resolution timer table, one row per user, one slot per timer.
// ----------------------------------------------------------------------------
// Flow: set, cancel and read pass the read, read-modify-write (valid slot and
//   row only) and output states; cancel all reads then writes each of the
//   user's eight slots. Poll: a countdown may walk the table (each slot read,
//   then written back if counting) and an event search follows; one item at
//   a time. Reset: a clearing pass writes every slot idle; no item is
//   accepted until it ends. Configuration writes are taken at any time.
module multi_user_timer_bank_unit (
  input  logic       clk,
  input  logic       rst_n,
  mutb_in_if.sink    in_ch,
  mutb_out_if.source out_ch,
  mutb_cfg_if.sink   cfg_ch
);
  import mutb_pkg::*;

  // ---- configuration registers
  logic [4:0] user_count_r;
  logic [7:0] first_ev_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_count_r <= 5'd16;
      first_ev_r   <= 8'd0;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.data.index))
        CFG_USER_COUNT:  user_count_r <= cfg_ch.data.data[4:0];
        CFG_FIRST_EVENT: first_ev_r   <= cfg_ch.data.data[7:0];
        default: ;
      endcase
    end
  end

  // rows in use, clamped to the table height
  logic [4:0] rows;
  assign rows = (user_count_r > 5'(MaxUsers)) ? 5'(MaxUsers) : user_count_r;

  // ---- state
  state_t state_r, state_nxt;
  in_item_t item_r;
  out_item_t res_r;
  out_item_t out_data_r;        // result waiting for the sink
  logic out_valid_r;
  logic [31:0] cur_t_r, last_t_r, next_exp_r;
  logic [7:0]  exp_cnt_r;
  logic [AddrW:0] cnt_r;        // sweep counter, can hold Depth
  logic [31:0] least_r;
  logic [31:0] delta_r;
  logic [31:0] elapsed_r;       // elapsed at item acceptance

  // ---- RAM
  logic            ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [31:0]     ram_wdata, ram_rdata;

  mutb_ram #(.Width(SlotDataW), .Depth(Depth)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // ---- decode of the held item
  logic [7:0] ev_off;
  logic       slot_ok, row_ok;
  logic [SlotW-1:0] slot;
  assign ev_off  = item_r.timer_event - first_ev_r;
  assign slot_ok = (item_r.timer_event >= first_ev_r) && (ev_off < 8'(SlotsPerUser));
  assign slot    = ev_off[SlotW-1:0];
  assign row_ok  = {1'b0, item_r.user_index} < rows;

  logic [31:0] elapsed_now;
  assign elapsed_now = (cur_t_r >= last_t_r) ? cur_t_r - last_t_r : 32'd0;

  logic accept_in;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept_in   = in_ch.valid && in_ch.ready;

  // scan address and end of walk
  logic [AddrW-1:0] scan_addr;
  logic [4:0]       scan_row;
  logic             scan_end;
  assign scan_addr = cnt_r[AddrW-1:0];
  assign scan_row  = {1'b0, cnt_r[AddrW-1:SlotW]};
  assign scan_end  = (cnt_r[AddrW] == 1'b1) || (scan_row >= rows);

  // pending read-back: in SCAN/TAKE, data for cnt_r-1 arrives from the RAM in the following cycle
  logic rd_pend_r;
  logic [AddrW-1:0] rd_addr_r;

  // ---- countdown arithmetic on the returned slot
  logic signed [31:0] v;
  logic [31:0] v_dec;
  assign v     = ram_rdata;
  assign v_dec = ram_rdata - delta_r;

  // ---- set arithmetic
  logic [32:0] set_sum;
  logic [31:0] set_val;
  logic [32:0] exp_sum;
  logic [31:0] exp_sat;
  logic [31:0] nx_base;
  assign set_sum = {1'b0, item_r.period} + {1'b0, elapsed_r};
  assign set_val = (set_sum > {1'b0, SlotMax}) ? SlotMax : set_sum[31:0];
  assign exp_sum = {1'b0, cur_t_r} + {1'b0, item_r.period};
  assign exp_sat = exp_sum[32] ? 32'hffff_ffff : exp_sum[31:0];
  assign nx_base = (next_exp_r != 32'd0 && next_exp_r < cur_t_r) ? cur_t_r : next_exp_r;

  // ---- read arithmetic
  logic signed [32:0] togo;
  assign togo = {v[31], v} - $signed({1'b0, elapsed_r});

  logic [31:0] lst_plus;
  logic [32:0] lst_sum;
  assign lst_sum  = {1'b0, cur_t_r} + {1'b0, least_r};
  assign lst_plus = lst_sum[32] ? 32'hffff_ffff : lst_sum[31:0];

  logic [7:0] cnt_dec;
  assign cnt_dec = (exp_cnt_r != 8'd0) ? exp_cnt_r - 8'd1 : 8'd0;

  // ---- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:   if (cnt_r == (AddrW+1)'(Depth - 1)) state_nxt = ST_IDLE;
      ST_IDLE:    if (accept_in) state_nxt = ST_RD;
      ST_RD: begin
        case (kind_t'(item_r.kind))
          KIND_SET, KIND_CANCEL, KIND_READ:
            state_nxt = (slot_ok && row_ok) ? ST_RMW : ST_OUT;
          KIND_CANALL: state_nxt = row_ok ? ST_CANALL : ST_OUT;
          KIND_POLL: begin
            if (exp_cnt_r != 8'd0) state_nxt = ST_TAKE;
            else if (next_exp_r == 32'd0 || next_exp_r > cur_t_r) state_nxt = ST_OUT;
            else state_nxt = ST_SCAN;
          end
          default: state_nxt = ST_OUT;
        endcase
      end
      ST_RMW:     state_nxt = ST_OUT;
      ST_CANALL:  if (cnt_r == (AddrW+1)'(2*SlotsPerUser - 1)) state_nxt = ST_OUT;
      ST_SCAN:    if (scan_end && !rd_pend_r) state_nxt = ST_TAKE;
      ST_TAKE: begin
        if (exp_cnt_r == 8'd0) state_nxt = ST_OUT;
        else if (rd_pend_r && ram_rdata == 32'd0) state_nxt = ST_TAKE_WB;
        else if (scan_end && !rd_pend_r) state_nxt = ST_OUT;
      end
      ST_TAKE_WB: state_nxt = ST_OUT;
      // hold until the output register is free
      ST_OUT:     if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // ---- RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = {item_r.user_index, slot};
    ram_wdata = SlotIdle;
    case (state_r)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = cnt_r[AddrW-1:0];
      end
      ST_RMW: begin
        if (kind_t'(item_r.kind) == KIND_SET && $signed(item_r.period) > 0) begin
          ram_we = 1'b1; ram_wdata = set_val;
        end else if (kind_t'(item_r.kind) == KIND_CANCEL) begin
          ram_we = 1'b1;
        end
      end
      ST_CANALL: begin
        // even steps read, odd steps write idle
        ram_addr = {item_r.user_index, cnt_r[SlotW:1]};
        ram_we   = cnt_r[0];
      end
      ST_SCAN: begin
        // write back the previous slot's count, else read the next
        if (rd_pend_r && v > 0) begin
          ram_we    = 1'b1;
          ram_addr  = rd_addr_r;
          ram_wdata = ($unsigned(v) <= delta_r) ? 32'd0 : v_dec;
        end else begin
          ram_addr = scan_addr;
        end
      end
      ST_TAKE: ram_addr = scan_addr;
      ST_TAKE_WB: begin
        ram_we   = 1'b1;
        ram_addr = rd_addr_r;
      end
      default: ;
    endcase
  end

  // ---- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      cur_t_r     <= '0;
      last_t_r    <= '0;
      next_exp_r  <= '0;
      exp_cnt_r   <= '0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // load the output register once it is free, else drop a taken result
      if (state_r == ST_OUT && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_r;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: cnt_r <= cnt_r + 1'b1;
        ST_IDLE: if (accept_in) begin
          item_r <= in_ch.data;
          res_r  <= '0;
          if (kind_t'(in_ch.data.kind) == KIND_POLL) cur_t_r <= in_ch.data.now_time;
          else elapsed_r <= elapsed_now;
          cnt_r     <= '0;
          rd_pend_r <= 1'b0;
        end
        ST_RD: begin
          if (kind_t'(item_r.kind) == KIND_SET || kind_t'(item_r.kind) == KIND_CANCEL
              || kind_t'(item_r.kind) == KIND_READ)
            res_r.bad_timer <= !slot_ok;
          if (kind_t'(item_r.kind) == KIND_POLL) begin
            least_r <= SlotMax;
            delta_r <= elapsed_now;
            if (exp_cnt_r == 8'd0 && (next_exp_r == 32'd0 || next_exp_r <= cur_t_r))
              last_t_r <= cur_t_r;
          end
        end
        ST_RMW: begin
          case (kind_t'(item_r.kind))
            KIND_SET: if ($signed(item_r.period) > 0) begin
              if (ram_rdata == 32'd0) exp_cnt_r <= cnt_dec;
              if (nx_base == 32'd0 || item_r.period < nx_base - cur_t_r)
                next_exp_r <= exp_sat;
              else next_exp_r <= nx_base;
            end
            KIND_CANCEL: if (ram_rdata == 32'd0) exp_cnt_r <= cnt_dec;
            KIND_READ: res_r.remaining <= (togo > 0) ? togo[30:0] : 31'd0;
            default: ;
          endcase
        end
        ST_CANALL: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r[0] && ram_rdata == 32'd0) exp_cnt_r <= cnt_dec;
        end
        ST_SCAN: begin
          if (rd_pend_r && v > 0) begin
            rd_pend_r <= 1'b0;
            if ($unsigned(v) <= delta_r) exp_cnt_r <= exp_cnt_r + 8'd1;
            else if (v_dec < least_r) least_r <= v_dec;
          end else if (rd_pend_r) begin
            rd_pend_r <= 1'b0;
          end else if (!scan_end) begin
            rd_pend_r <= 1'b1;
            rd_addr_r <= scan_addr;
            cnt_r     <= cnt_r + 1'b1;
          end else begin
            next_exp_r <= (least_r < SlotMax) ? lst_plus : 32'd0;
            cnt_r      <= '0;
          end
        end
        ST_TAKE: begin
          if (rd_pend_r && ram_rdata == 32'd0) begin
            // hold rd_addr_r so the write-back idles the reported slot
            res_r.event_valid <= 1'b1;
            res_r.event_user  <= rd_addr_r[AddrW-1:SlotW];
            res_r.event_timer <= first_ev_r + {5'd0, rd_addr_r[SlotW-1:0]};
            exp_cnt_r         <= cnt_dec;
            rd_pend_r         <= 1'b0;
          end else begin
            if (exp_cnt_r != 8'd0 && scan_end && !rd_pend_r) exp_cnt_r <= '0;
            if (!scan_end) begin
              rd_pend_r <= 1'b1;
              rd_addr_r <= scan_addr;
              cnt_r     <= cnt_r + 1'b1;
            end else begin
              rd_pend_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // ---- checks
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("result dropped or changed while waiting");
  a_result_after: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |=> out_valid_r) else $error("result not raised");
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ch.ready) else $error("item taken during clear");
endmodule

/* test/tb_multi_user_timer_bank_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank testbench
// Drives commands and polls into the timer bank under random stalls, predicts
// every result from a behavioural copy of the lazy timer table, and compares
// each result field by field in order.
// ----------------------------------------------------------------------------
module tb_multi_user_timer_bank_unit;
  import mutb_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned DrainWait  = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mutb_in_if  in_ch ();
  mutb_out_if out_ch ();
  mutb_cfg_if cfg_ch ();

  multi_user_timer_bank_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always #4 clk = ~clk;

  // Shadow copy of the timer table and its bookkeeping
  logic signed [31:0] slot_tbl [MaxUsers][SlotsPerUser];
  logic [31:0] now_s, last_upd, next_exp, exp_cnt;
  logic [4:0]  rows_cfg;
  logic [7:0]  first_ev;

  out_item_t   expected_q [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;    // hold both sides busy-free when set
  logic [31:0] stim_now = 0;    // time base for random polls

  task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
    $display("mismatch %s: expected %0h got %0h (cycle %0d)", what, exp_v, got_v, cycles);
    errors++;
  endtask

  function automatic int unsigned rows_used();
    return (rows_cfg > MaxUsers) ? MaxUsers : rows_cfg;
  endfunction

  function automatic logic [31:0] elapsed_s();
    return (now_s >= last_upd) ? now_s - last_upd : 32'd0;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hffff_ffff : s[31:0];
  endfunction

  function automatic void drop_expired();
    if (exp_cnt != 0) exp_cnt--;
  endfunction

  function automatic void idle_slot(input int u, input int k);
    if (slot_tbl[u][k] == 0) drop_expired();
    slot_tbl[u][k] = SlotIdle;
  endfunction

  // Report the first expired slot in user-then-slot order, if any
  function automatic void take_expired(inout out_item_t r);
    if (exp_cnt == 0) return;
    for (int i = 0; i < rows_used(); i++) begin
      for (int k = 0; k < SlotsPerUser; k++) begin
        if (slot_tbl[i][k] == 0) begin
          slot_tbl[i][k] = SlotIdle;
          drop_expired();
          r.event_valid = 1'b1;
          r.event_user  = i[3:0];
          r.event_timer = first_ev + k[7:0];
          return;
        end
      end
    end
    exp_cnt = 0;
  endfunction

  function automatic void poll_table(input logic [31:0] t, inout out_item_t r);
    logic [31:0] delta;
    logic signed [31:0] least, v;
    least = SlotMax;
    now_s = t;
    if (exp_cnt != 0) begin
      take_expired(r);
      return;
    end
    if (next_exp == 0) begin
      last_upd = now_s;
      return;
    end
    if (next_exp > now_s) return;
    delta = elapsed_s();
    last_upd = now_s;
    for (int i = 0; i < rows_used(); i++) begin
      for (int k = 0; k < SlotsPerUser; k++) begin
        v = slot_tbl[i][k];
        if (v > 0) begin
          if (v <= delta) begin
            slot_tbl[i][k] = 0;
            exp_cnt++;
          end else begin
            v = v - delta;
            slot_tbl[i][k] = v;
            if (v < least) least = v;
          end
        end
      end
    end
    next_exp = (least < SlotMax) ? sat_add(now_s, least) : 32'd0;
    if (exp_cnt != 0) take_expired(r);
  endfunction

  // Work out the result of one accepted item and advance the shadow state
  function automatic out_item_t timer_bank_result(input in_item_t it);
    out_item_t r;
    logic [7:0] off;
    bit slot_ok, row_ok;
    int slot;
    logic signed [63:0] v, togo;
    r = '0;
    off = it.timer_event - first_ev;
    slot_ok = (it.timer_event >= first_ev) && (off < SlotsPerUser);
    slot = slot_ok ? int'(off) : 0;
    row_ok = it.user_index < rows_used();
    if (it.kind <= KIND_READ && !slot_ok) r.bad_timer = 1'b1;
    case (it.kind)
      KIND_SET: begin
        if (slot_ok && row_ok && $signed(it.period) > 0) begin
          v = $signed({32'd0, it.period}) + $signed({32'd0, elapsed_s()});
          if (slot_tbl[it.user_index][slot] == 0) drop_expired();
          slot_tbl[it.user_index][slot] = (v > SlotMax) ? SlotMax : v[31:0];
          if (next_exp > 0 && next_exp < now_s) next_exp = now_s;
          if (next_exp == 0 || it.period < next_exp - now_s)
            next_exp = sat_add(now_s, it.period);
        end
      end
      KIND_CANCEL: if (slot_ok && row_ok) idle_slot(it.user_index, slot);
      KIND_READ: begin
        if (slot_ok && row_ok) begin
          togo = 64'(slot_tbl[it.user_index][slot]) - $signed({32'd0, elapsed_s()});
          r.remaining = (togo > 0) ? togo[30:0] : 31'd0;
        end
      end
      KIND_CANALL: begin
        if (row_ok)
          for (int k = 0; k < SlotsPerUser; k++) idle_slot(it.user_index, k);
      end
      KIND_POLL: poll_table(it.now_time, r);
      default: ;
    endcase
    return r;
  endfunction

  // Send one item; called at a falling edge, returns at a falling edge
  task automatic send_item(input in_item_t it);
    if (!quiet && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < 13) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(timer_bank_result(it));
    @(negedge clk);
  endtask

  task automatic send_cmd(input kind_t k, input int u, input int ev,
                          input logic [31:0] per, input logic [31:0] t);
    in_item_t it;
    it.kind = k;
    it.user_index = u[3:0];
    it.timer_event = ev[7:0];
    it.period = per;
    it.now_time = t;
    send_item(it);
  endtask

  // Lower valid and hold until every expected result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_USER_COUNT) rows_cfg = val[4:0];
    else first_ev = val[7:0];
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Setting, cancelling, reading, expiry and poll corner cases
  task automatic test_commands();
    send_cmd(KIND_POLL, 0, 0, 0, 32'd10);
    send_cmd(KIND_SET, 0, 0, 32'd5, 0);
    send_cmd(KIND_SET, 15, 7, 32'h7fff_ffff, 0);
    send_cmd(KIND_SET, 1, 2, 32'd0, 0);               // zero period: no change
    send_cmd(KIND_SET, 1, 3, 32'h8000_0000, 0);       // negative period
    send_cmd(KIND_READ, 0, 0, 0, 0);
    send_cmd(KIND_READ, 2, 1, 0, 0);                  // idle slot reads zero
    send_cmd(KIND_SET, 0, 8, 32'd3, 0);               // out of range timer
    send_cmd(KIND_CANCEL, 0, 255, 0, 0);
    send_cmd(KIND_POLL, 0, 0, 0, 32'd12);
    send_cmd(KIND_POLL, 0, 0, 0, 32'd20);             // first expiry
    send_cmd(KIND_SET, 3, 1, 32'd1, 0);
    send_cmd(KIND_SET, 3, 2, 32'd1, 0);
    send_cmd(KIND_POLL, 0, 0, 0, 32'd25);             // two expire, one reported
    send_cmd(KIND_CANCEL, 3, 2, 0, 0);                // cancel an expired slot
    send_cmd(KIND_POLL, 0, 0, 0, 32'd26);
    send_cmd(KIND_SET, 4, 4, 32'd3, 0);
    send_cmd(KIND_CANALL, 4, 0, 0, 0);
    send_cmd(kind_t'(3'd5), 5, 5, 32'hffff_ffff, 32'hffff_ffff);
    send_cmd(kind_t'(3'd7), 15, 255, 0, 0);
    send_cmd(KIND_POLL, 0, 0, 0, 32'd5);              // time runs backwards
    send_cmd(KIND_POLL, 0, 0, 0, 32'hffff_ffff);
    send_cmd(KIND_READ, 15, 7, 0, 0);
    drain();
  endtask

  // Rows out of use and a shifted event base
  task automatic test_row_limits();
    write_reg(CFG_FIRST_EVENT, 32'd250);
    send_cmd(KIND_POLL, 0, 0, 0, 32'd100);
    send_cmd(KIND_SET, 5, 251, 32'd1, 0);
    send_cmd(KIND_POLL, 0, 0, 0, 32'd102);            // expires and is reported
    drain();
    write_reg(CFG_USER_COUNT, 32'd1);
    send_cmd(KIND_SET, 1, 250, 32'd2, 0);             // row not in use
    send_cmd(KIND_READ, 3, 249, 0, 0);
    send_cmd(KIND_POLL, 0, 0, 0, 32'd103);            // no event
    send_cmd(KIND_SET, 0, 255, 32'd2, 0);
    send_cmd(KIND_READ, 0, 255, 0, 0);
    drain();
    write_reg(CFG_USER_COUNT, 32'd0);
    send_cmd(KIND_CANALL, 0, 0, 0, 0);
    send_cmd(KIND_POLL, 0, 0, 0, 32'd110);
    drain();
    write_reg(CFG_USER_COUNT, 32'd31);
    send_cmd(KIND_POLL, 0, 0, 0, 32'd111);
    drain();
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned pick;
    pick = $urandom_range(99);
    it.kind = (pick < 35) ? KIND_SET : (pick < 45) ? KIND_CANCEL :
              (pick < 60) ? KIND_READ : (pick < 65) ? KIND_CANALL :
              (pick < 98) ? KIND_POLL : kind_t'(3'($urandom_range(7, 5)));
    it.user_index = 4'($urandom);
    it.timer_event = ($urandom_range(9) == 0) ? 8'($urandom)
                                               : first_ev + 8'($urandom_range(7));
    pick = $urandom_range(99);
    it.period = (pick < 85) ? $urandom_range(12, 1) : (pick < 90) ? 32'd0 :
                (pick < 95) ? ($urandom | 32'h8000_0000) : $urandom;
    if ($urandom_range(99) < 3) stim_now = $urandom;
    else stim_now = stim_now + $urandom_range(4);
    it.now_time = stim_now;
    return it;
  endfunction

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      send_item(random_item());
      if (i == n / 2) drain();                       // hold off until all back
    end
    drain();
  endtask

  // Random traffic across several register settings
  task automatic test_random_settings();
    quiet = 1'b1;                                    // long stretch, no idling
    write_reg(CFG_USER_COUNT, 32'd16);
    write_reg(CFG_FIRST_EVENT, 32'd0);
    test_random(100);
    quiet = 1'b0;
    write_reg(CFG_FIRST_EVENT, 32'd255);
    test_random(80);
    write_reg(CFG_USER_COUNT, 32'd1);
    write_reg(CFG_FIRST_EVENT, 32'd100);
    test_random(80);
    write_reg(CFG_USER_COUNT, 32'd7);
    write_reg(CFG_FIRST_EVENT, 32'd3);
    test_random(140);
  endtask

  // Receiver: drop ready at random
  always @(negedge clk) begin
    out_ch.ready <= quiet || ($urandom_range(99) >= 13);
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", 32'd0, 32'(out_ch.data.remaining));
      end else begin
        want = expected_q.pop_front();
        if (out_ch.data.event_valid != want.event_valid)
          report("event_valid", 32'(want.event_valid), 32'(out_ch.data.event_valid));
        if (out_ch.data.event_user != want.event_user)
          report("event_user", 32'(want.event_user), 32'(out_ch.data.event_user));
        if (out_ch.data.event_timer != want.event_timer)
          report("event_timer", 32'(want.event_timer), 32'(out_ch.data.event_timer));
        if (out_ch.data.remaining != want.remaining)
          report("remaining", 32'(want.remaining), 32'(out_ch.data.remaining));
        if (out_ch.data.bad_timer != want.bad_timer)
          report("bad_timer", 32'(want.bad_timer), 32'(out_ch.data.bad_timer));
      end
    end
  end

  // Advance the cycle count and stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_multi_user_timer_bank_unit failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < MaxUsers; i++)
      for (int k = 0; k < SlotsPerUser; k++) slot_tbl[i][k] = SlotIdle;
    now_s = 0;
    last_upd = 0;
    next_exp = 0;
    exp_cnt = 0;
    rows_cfg = 5'd16;
    first_ev = 8'd0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_commands();
    test_row_limits();
    test_random_settings();
    if (expected_q.size() == 0 && errors == 0) begin
      $display("tb_multi_user_timer_bank_unit passed");
    end else begin
      $display("tb_multi_user_timer_bank_unit failed");
    end
    $finish;
  end

endmodule
